[hw/rtl/deq_pkg.sv]
package deq_pkg;

	localparam int unsigned DEQ_CAPACITY = 64;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned CNT_W    = 7;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_MISS  = 2'd3;

	// per-cycle action of every cell in a chain
	typedef enum logic [2:0] {
		COP_HOLD,
		COP_SHR,
		COP_SHL,
		COP_PUT,
		COP_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                op;
		logic signed [KEY_W-1:0] key;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

endpackage

[hw/rtl/deq_if.sv]
interface deq_req_if;
	logic                             valid;
	logic                             ready;
	logic [deq_pkg::CMD_W-1:0]        command;
	logic signed [deq_pkg::KEY_W-1:0] key_in;

	modport source (output valid, command, key_in, input ready);
	modport sink (input valid, command, key_in, output ready);
endinterface

interface deq_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [deq_pkg::STATUS_W-1:0]     status;
	logic signed [deq_pkg::KEY_W-1:0] key_out;
	logic [deq_pkg::POS_W-1:0]        position;
	logic [deq_pkg::CNT_W-1:0]        count;
	logic signed [deq_pkg::KEY_W-1:0] front_key;
	logic signed [deq_pkg::KEY_W-1:0] back_key;

	modport source (output valid, status, key_out, position, count, front_key, back_key,
		input ready);
	modport sink (input valid, status, key_out, position, count, front_key, back_key,
		output ready);
endinterface

[hw/rtl/deq_cell.sv]
module deq_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 7
) (
	input  logic                             clk,
	input  deq_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                    count,
	input  logic signed [deq_pkg::KEY_W-1:0] lo,
	input  logic signed [deq_pkg::KEY_W-1:0] hi,
	input  logic signed [deq_pkg::KEY_W-1:0] wrap,
	output logic signed [deq_pkg::KEY_W-1:0] data
);
	import deq_pkg::*;

	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] LAST_C = CW'(IDX + 1);

	logic signed [KEY_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			COP_HOLD: ;
			COP_SHR:  data_q <= lo;
			COP_SHL:  data_q <= hi;
			COP_PUT: begin
				if (count == IDX_C)
					data_q <= ctl.key;
			end
			// last live cell takes the front, so the window turns round
			COP_ROT:  data_q <= (count == LAST_C) ? wrap : hi;
			default: ;
		endcase
	end

	assign data = data_q;

endmodule

[hw/rtl/deq_chain.sv]
module deq_chain #(
	parameter int unsigned DEPTH = deq_pkg::DEQ_CAPACITY,
	parameter int unsigned CW    = 7
) (
	input  logic                             clk,
	input  deq_pkg::cell_ctl_t               ctl,
	input  logic [CW-1:0]                    count,
	output logic signed [deq_pkg::KEY_W-1:0] head
);
	import deq_pkg::*;

	logic signed [KEY_W-1:0] data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [KEY_W-1:0] lo;
		logic signed [KEY_W-1:0] hi;

		if (i == 0) begin : g_first
			assign lo = ctl.key;
		end else begin : g_lo
			assign lo = data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign hi = '0;
		end else begin : g_hi
			assign hi = data[i+1];
		end

		deq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.count (count),
			.lo    (lo),
			.hi    (hi),
			.wrap  (data[0]),
			.data  (data[i])
		);
	end

	assign head = data[0];

endmodule

[hw/rtl/double_ended_queue_with_search.sv]
// Bounded deque of signed 32-bit keys held in two rows of cells: one row keeps
// the queue front first, the other back first, so both ends sit in cell 0 and
// every push, pop and clear is done without a walk. A search of an empty queue
// is a miss without a walk; otherwise the front row turns round one cell per
// cycle past a single comparator until every live key has passed and the order
// is restored; no request is taken meanwhile. Each request gives one response,
// held in an output register; a new request is taken in the cycle the pending
// response is taken. front_key, back_key and count follow the live cells.
module double_ended_queue_with_search #(
	parameter int unsigned CAPACITY = deq_pkg::DEQ_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	deq_req_if.sink   req,
	deq_rsp_if.source rsp
);
	import deq_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = $clog2(CAPACITY);
	localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);

	state_t state_q, state_d;

	logic [CW-1:0]           count_q, count_d;
	logic [PW-1:0]           step_q;
	logic [PW-1:0]           pos_q;
	logic                    hit_q;
	logic signed [KEY_W-1:0] skey_q;

	logic                    rsp_valid_q;
	logic [STATUS_W-1:0]     status_q, status_d;
	logic signed [KEY_W-1:0] key_out_q, key_d;
	logic [PW-1:0]           rpos_q, pos_d;
	logic                    load;

	cell_op_t  a_op, b_op;
	cell_ctl_t a_ctl, b_ctl;
	logic signed [KEY_W-1:0] a_head, b_head;

	logic accept, empty, full, match, last_step;
	logic [PW+POS_W-1:0] pos_ext;
	logic [CW+CNT_W-1:0] cnt_ext;

	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_C);
	assign match     = (a_head == skey_q);
	assign last_step = ((CW'(step_q) + CW'(1)) == count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.command == CMD_SEARCH && !empty)
					state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (last_step)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		a_op     = COP_HOLD;
		b_op     = COP_HOLD;
		count_d  = count_q;
		load     = 1'b0;
		status_d = STAT_OK;
		key_d    = '0;
		pos_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (req.command)
						CMD_PUSH_FRONT: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								a_op    = COP_SHR;
								b_op    = COP_PUT;
								count_d = count_q + CW'(1);
							end
						end
						CMD_PUSH_BACK: begin
							if (full) begin
								status_d = STAT_FULL;
							end else begin
								a_op    = COP_PUT;
								b_op    = COP_SHR;
								count_d = count_q + CW'(1);
							end
						end
						CMD_POP_FRONT: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								key_d   = a_head;
								a_op    = COP_SHL;
								count_d = count_q - CW'(1);
							end
						end
						CMD_POP_BACK: begin
							if (empty) begin
								status_d = STAT_EMPTY;
							end else begin
								key_d   = b_head;
								b_op    = COP_SHL;
								count_d = count_q - CW'(1);
							end
						end
						CMD_SEARCH: begin
							if (empty)
								status_d = STAT_MISS;
							else
								load = 1'b0;
						end
						CMD_CLEAR: count_d = '0;
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				a_op = COP_ROT;
				if (last_step) begin
					load = 1'b1;
					if (hit_q) begin
						pos_d = pos_q;
					end else if (match) begin
						pos_d = step_q;
					end else begin
						status_d = STAT_MISS;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= status_d;
			key_out_q <= key_d;
			rpos_q    <= pos_d;
		end
		if (accept && req.command == CMD_SEARCH) begin
			step_q <= '0;
			hit_q  <= 1'b0;
			skey_q <= req.key_in;
		end else if (state_q == S_SEARCH) begin
			step_q <= step_q + PW'(1);
			if (match && !hit_q) begin
				hit_q <= 1'b1;
				pos_q <= step_q;
			end
		end
	end

	assign a_ctl = '{op: a_op, key: req.key_in};
	assign b_ctl = '{op: b_op, key: req.key_in};

	deq_chain #(
		.DEPTH (CAPACITY),
		.CW    (CW)
	) u_front_row (
		.clk   (clk),
		.ctl   (a_ctl),
		.count (count_q),
		.head  (a_head)
	);

	deq_chain #(
		.DEPTH (CAPACITY),
		.CW    (CW)
	) u_back_row (
		.clk   (clk),
		.ctl   (b_ctl),
		.count (count_q),
		.head  (b_head)
	);

	assign pos_ext = {{POS_W{1'b0}}, rpos_q};
	assign cnt_ext = {{CNT_W{1'b0}}, count_q};

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.key_out   = key_out_q;
	assign rsp.position  = pos_ext[POS_W-1:0];
	assign rsp.count     = cnt_ext[CNT_W-1:0];
	assign rsp.front_key = empty ? '0 : a_head;
	assign rsp.back_key  = empty ? '0 : b_head;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("entry count above capacity");

	a_search_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> !req.ready && !rsp_valid_q)
		else $error("request or response open during search");

	a_search_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == CMD_SEARCH && !empty |=> state_q == S_SEARCH)
		else $error("search on live queue did not start walk");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == CMD_POP_FRONT && !empty
		|=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not drop count");

	a_search_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |=> count_q == $past(count_q))
		else $error("count changed during search");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import deq_pkg::*;

	localparam int unsigned CAP = DEQ_CAPACITY;
	localparam int RAND_ITEMS = 500;
	localparam int HOLD_CYCLES = 200;
	localparam int N_DIR = 23;

	localparam logic [CMD_W-1:0] CMD_NOP_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_NOP_HI = 3'd7;

	localparam logic signed [KEY_W-1:0] KMAX = 32'sh7fffffff;
	localparam logic signed [KEY_W-1:0] KMIN = 32'sh80000000;
	localparam logic signed [KEY_W-1:0] KNEG = -32'sd1;

	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic signed [KEY_W-1:0] key_out;
		logic [POS_W-1:0]        position;
		logic [CNT_W-1:0]        count;
		logic signed [KEY_W-1:0] front_key;
		logic signed [KEY_W-1:0] back_key;
	} deq_rsp_t;

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic signed [KEY_W-1:0] key;
		logic                    fixed;
		deq_rsp_t                want;
	} dir_row_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_HUNT} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_with_search dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow deque
	logic signed [KEY_W-1:0] ring [CAP];
	int unsigned head = 0;
	int unsigned live = 0;

	deq_rsp_t rsp_expected_q [$];
	dir_row_t dir_rows [N_DIR];

	int n_errors = 0;
	int n_reqs = 0;
	int n_checked = 0;
	int n_full = 0;
	int n_empty = 0;
	int n_hits = 0;
	int n_misses = 0;
	int n_rand = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	initial forever #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic deq_rsp_t deq_predict(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key);
		deq_rsp_t r;
		bit found;
		r = '0;
		found = 1'b0;
		r.status = STAT_OK;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (live >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					head = (head + CAP - 1) % CAP;
					ring[head] = key;
					live++;
				end
			end
			CMD_PUSH_BACK: begin
				if (live >= CAP) begin
					r.status = STAT_FULL;
				end else begin
					ring[(head + live) % CAP] = key;
					live++;
				end
			end
			CMD_POP_FRONT: begin
				if (live == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.key_out = ring[head];
					head = (head + 1) % CAP;
					live--;
				end
			end
			CMD_POP_BACK: begin
				if (live == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.key_out = ring[(head + live - 1) % CAP];
					live--;
				end
			end
			CMD_SEARCH: begin
				r.status = STAT_MISS;
				for (int i = 0; i < live; i++) begin
					if (!found && ring[(head + i) % CAP] == key) begin
						found = 1'b1;
						r.status = STAT_OK;
						r.position = POS_W'(i);
					end
				end
			end
			CMD_CLEAR: begin
				live = 0;
			end
			default: begin
			end
		endcase
		r.count = CNT_W'(live);
		if (live != 0) begin
			r.front_key = ring[head];
			r.back_key = ring[(head + live - 1) % CAP];
		end
		return r;
	endfunction

	function automatic void cmp_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_errors++;
		end
	endfunction

	always @(posedge clk) begin
		deq_rsp_t w;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_expected_q.size() == 0) begin
				$error("response with no request outstanding");
				n_errors++;
			end else begin
				w = rsp_expected_q.pop_front();
				cmp_field("status", KEY_W'(w.status), KEY_W'(rsp_ch.status));
				cmp_field("key_out", w.key_out, rsp_ch.key_out);
				cmp_field("position", KEY_W'(w.position), KEY_W'(rsp_ch.position));
				cmp_field("count", KEY_W'(w.count), KEY_W'(rsp_ch.count));
				cmp_field("front_key", w.front_key, rsp_ch.front_key);
				cmp_field("back_key", w.back_key, rsp_ch.back_key);
				n_checked++;
			end
		end
	end

	// response side: random back-pressure, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 12);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_req(logic [CMD_W-1:0] cmd, logic signed [KEY_W-1:0] key,
		logic fixed, deq_rsp_t want);
		deq_rsp_t p;
		if (!calm) begin
			while ($urandom_range(0, 99) < 12) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.key_in <= key;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		p = deq_predict(cmd, key);
		if (p.status == STAT_FULL) n_full++;
		if (p.status == STAT_EMPTY) n_empty++;
		if (cmd == CMD_SEARCH && p.status == STAT_OK) n_hits++;
		if (p.status == STAT_MISS) n_misses++;
		rsp_expected_q.push_back(fixed ? want : p);
		n_reqs++;
		@(negedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return KMAX;
			1: return KMIN;
			2: return '0;
			3: return KNEG;
			4, 5: return $urandom_range(1, 6);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [CMD_W-1:0] pick_cmd(mix_t m);
		int p;
		p = $urandom_range(0, 99);
		case (m)
			MIX_FILL: begin
				if (p < 42) return CMD_PUSH_FRONT;
				else if (p < 85) return CMD_PUSH_BACK;
				else if (p < 95) return CMD_SEARCH;
				else if (p < 98) return CMD_POP_FRONT;
				else return CMD_POP_BACK;
			end
			MIX_DRAIN: begin
				if (p < 35) return CMD_POP_FRONT;
				else if (p < 70) return CMD_POP_BACK;
				else if (p < 85) return CMD_SEARCH;
				else if (p < 95) return CMD_PUSH_BACK;
				else return CMD_PUSH_FRONT;
			end
			MIX_HUNT: begin
				if (p < 55) return CMD_SEARCH;
				else if (p < 70) return CMD_PUSH_FRONT;
				else if (p < 85) return CMD_PUSH_BACK;
				else if (p < 92) return CMD_POP_FRONT;
				else return CMD_POP_BACK;
			end
			default: begin
				if (p < 20) return CMD_PUSH_FRONT;
				else if (p < 40) return CMD_PUSH_BACK;
				else if (p < 55) return CMD_POP_FRONT;
				else if (p < 70) return CMD_POP_BACK;
				else if (p < 90) return CMD_SEARCH;
				else if (p < 94) return CMD_CLEAR;
				else if (p < 97) return CMD_NOP_LO;
				else return CMD_NOP_HI;
			end
		endcase
	endfunction

	task automatic send_random(mix_t m);
		logic [CMD_W-1:0] cmd;
		logic signed [KEY_W-1:0] key;
		calm = (n_rand >= 100 && n_rand < 200);
		if (n_rand == 300) hold_req = 1'b1;
		cmd = pick_cmd(m);
		key = pick_key();
		if (cmd == CMD_SEARCH && live != 0 && $urandom_range(0, 99) < 60)
			key = ring[(head + $urandom_range(0, live - 1)) % CAP];
		send_req(cmd, key, 1'b0, '0);
		n_rand++;
	endtask

	initial begin
		mix_t m;
		int seg;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_PUSH_FRONT;
		req_ch.key_in = '0;

		dir_rows = '{
			'{CMD_POP_FRONT,  '0,   1'b1, '{STAT_EMPTY, 0, 0, 0, 0, 0}},
			'{CMD_POP_BACK,   KNEG, 1'b1, '{STAT_EMPTY, 0, 0, 0, 0, 0}},
			'{CMD_SEARCH,     '0,   1'b1, '{STAT_MISS, 0, 0, 0, 0, 0}},
			'{CMD_NOP_LO,     KMAX, 1'b1, '{STAT_OK, 0, 0, 0, 0, 0}},
			'{CMD_NOP_HI,     KNEG, 1'b1, '{STAT_OK, 0, 0, 0, 0, 0}},
			'{CMD_PUSH_FRONT, KMAX, 1'b1, '{STAT_OK, 0, 0, 1, KMAX, KMAX}},
			'{CMD_PUSH_BACK,  KMIN, 1'b1, '{STAT_OK, 0, 0, 2, KMAX, KMIN}},
			'{CMD_PUSH_FRONT, KNEG, 1'b1, '{STAT_OK, 0, 0, 3, KNEG, KMIN}},
			'{CMD_SEARCH,     KMIN, 1'b1, '{STAT_OK, 0, 2, 3, KNEG, KMIN}},
			'{CMD_SEARCH,     '0,   1'b1, '{STAT_MISS, 0, 0, 3, KNEG, KMIN}},
			'{CMD_SEARCH,     KMAX, 1'b0, '0},
			'{CMD_POP_BACK,   '0,   1'b1, '{STAT_OK, KMIN, 0, 2, KNEG, KMAX}},
			'{CMD_POP_FRONT,  '0,   1'b1, '{STAT_OK, KNEG, 0, 1, KMAX, KMAX}},
			'{CMD_CLEAR,      '0,   1'b1, '{STAT_OK, 0, 0, 0, 0, 0}},
			'{CMD_POP_BACK,   '0,   1'b1, '{STAT_EMPTY, 0, 0, 0, 0, 0}},
			'{CMD_SEARCH,     KMAX, 1'b1, '{STAT_MISS, 0, 0, 0, 0, 0}},
			'{CMD_PUSH_BACK,  32'sh5a5a5a5a, 1'b0, '0},
			'{CMD_PUSH_FRONT, 32'sha5a5a5a5, 1'b0, '0},
			'{CMD_NOP_LO,     '0,   1'b0, '0},
			'{CMD_SEARCH,     32'sh5a5a5a5a, 1'b0, '0},
			'{CMD_POP_FRONT,  '0,   1'b0, '0},
			'{CMD_POP_FRONT,  '0,   1'b0, '0},
			'{CMD_POP_FRONT,  '0,   1'b0, '0}
		};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_req(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].fixed, dir_rows[i].want);

		// first segment fills to the brim and pushes into a full queue
		m = MIX_FILL;
		while (n_rand < RAND_ITEMS) begin
			if (m == MIX_FILL) begin
				seg = 0;
				while (live < CAP && seg < 250) begin
					send_random(MIX_FILL);
					seg++;
				end
				repeat (4) send_random(MIX_FILL);
			end else begin
				repeat ($urandom_range(20, 60)) send_random(m);
			end
			m = mix_t'($urandom_range(0, 3));
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		while (rsp_expected_q.size() != 0) @(posedge clk);
		repeat (CAP + 16) @(posedge clk);

		$display("%0d requests checked (%0d random); %0d full pushes, %0d empty pops",
			n_checked, n_rand, n_full, n_empty);
		$display("searches: %0d hits, %0d misses", n_hits, n_misses);
		if (n_errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
